>>> sv/lms_pkg.sv
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types and constants of the link mode supervisor: event and action
// codes, link states, register indexes and the bundles between the units.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int MAX_RES   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int STEP_W    = 10;
    localparam int DELAY_W   = 26;  // 1023 min * 60000 ms fits in 26 bits
    localparam int IP_W      = 32;
    localparam int CNT_W     = 8;

    localparam logic [15:0] MS_PER_MIN = 16'd60000;

    localparam logic [CFG_DAT_W-1:0] RST_STA_BUDGET  = 24'd30000;
    localparam logic [CFG_DAT_W-1:0] RST_QUIET_GUARD = 24'd60000;
    localparam logic [3:0][STEP_W-1:0] RST_STEP_MIN = {10'd10, 10'd5, 10'd2, 10'd1};

    localparam logic [CFG_IDX_W-1:0] CFG_STA_BUDGET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_GUARD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_STEP0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_STEP1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_STEP2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_STEP3 = 3'd5;

    localparam logic MODE_AP  = 1'b0;
    localparam logic MODE_STA = 1'b1;

    typedef enum logic [2:0] {
        FN_START         = 3'd0,
        FN_AP_STARTED    = 3'd1,
        FN_STA_CONNECTED = 3'd2,
        FN_STA_LOST      = 3'd3,
        FN_CLIENT_COUNT  = 3'd4,
        FN_ACTIVITY      = 3'd5,
        FN_SET_MODE      = 3'd6,
        FN_TICK          = 3'd7
    } t_func;

    typedef enum logic [3:0] {
        ACT_NONE           = 4'd0,
        ACT_START_AP       = 4'd1,
        ACT_STOP_AP        = 4'd2,
        ACT_STA_CONNECT    = 4'd3,
        ACT_STA_DISCONNECT = 4'd4,
        ACT_EVT_FALLBACK   = 4'd5,
        ACT_EVT_AP_UP      = 4'd6,
        ACT_EVT_STA_UP     = 4'd7,
        ACT_EVT_STA_LOST   = 4'd8
    } t_action;

    typedef enum logic [2:0] {
        ST_AP_STARTING    = 3'd0,
        ST_AP_UP          = 3'd1,
        ST_STA_CONNECTING = 3'd2,
        ST_STA_UP         = 3'd3,
        ST_FALLBACK_AP    = 3'd4,
        ST_IDLE           = 3'd5
    } t_link_state;

    typedef struct packed {
        logic [CFG_DAT_W-1:0]          sta_budget;
        logic [CFG_DAT_W-1:0]          quiet_guard;
        logic [3:0][DELAY_W-1:0]       retry_delay;
    } t_cfg;

    // all results caused by one event
    typedef struct packed {
        logic [1:0]                    cnt;
        t_action [MAX_RES-1:0]         act;
        logic [IP_W-1:0]               ip;
        t_link_state                   state;
    } t_bundle;

endpackage

>>> sv/lms_ifs.sv
// ----------------------------------------------------------------------------
// lms channel interfaces
// Event, result and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface lms_evt_if #(
    parameter int TIME_BITS = 48
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   func;
    logic [TIME_BITS-1:0]         now_ms;
    logic                         mode_req;
    logic                         force_ap;
    logic [lms_pkg::IP_W-1:0]     ip_addr;
    logic [lms_pkg::CNT_W-1:0]    client_count;

    modport source (output valid, func, now_ms, mode_req, force_ap, ip_addr, client_count,
                    input ready);
    modport sink (input valid, func, now_ms, mode_req, force_ap, ip_addr, client_count,
                  output ready);
endinterface

interface lms_res_if;
    logic                         valid;
    logic                         ready;
    logic [3:0]                   action;
    logic [lms_pkg::IP_W-1:0]     event_ip;
    logic [2:0]                   link_state;
    logic                         last;

    modport source (output valid, action, event_ip, link_state, last, input ready);
    modport sink (input valid, action, event_ip, link_state, last, output ready);
endinterface

interface lms_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lms_pkg::CFG_IDX_W-1:0]    index;
    logic [lms_pkg::CFG_DAT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/link_mode_supervisor.sv
// ----------------------------------------------------------------------------
// link_mode_supervisor
// Station / access point supervisor with timed fallback and retry ladder.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries one event per transaction (func, time stamp and operands).
//   o_res returns one to three actions per event; last marks the final one
//   and link_state gives the state after the event in each of them.
//   i_cfg writes the budget, quiet guard and retry step registers by index;
//   writes are taken every cycle and belong to idle periods only.
// Timing:
//   an event is registered, decided combinationally into the result register
//   and offered from there as its first action once that register is free.
//   The result register hands out one action per cycle while the receiver is
//   ready; the next event is taken while the current results drain and waits
//   in the event register.
// Reset: synchronous, active low; link idle, registers at their defaults.
// A stalled receiver holds the current action; once the event register is
//   also full, i_evt.ready drops until the final action is taken.
// ----------------------------------------------------------------------------
module link_mode_supervisor #(
    parameter int RETRY_STEPS = 4,
    parameter int TIME_BITS   = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lms_evt_if.sink     i_evt,
    lms_cfg_if.sink     i_cfg,
    lms_res_if.source   o_res
);

    lms_pkg::t_cfg     cfg;
    lms_pkg::t_bundle  bundle;
    logic              load_valid;
    logic              load_ready;

    lms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    lms_core #(
        .RETRY_STEPS (RETRY_STEPS),
        .TIME_BITS   (TIME_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt        (i_evt),
        .i_cfg        (cfg),
        .o_bundle     (bundle),
        .o_load_valid (load_valid),
        .i_load_ready (load_ready)
    );

    lms_out_seq u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bundle     (bundle),
        .i_load_valid (load_valid),
        .o_load_ready (load_ready),
        .o_res        (o_res)
    );

endmodule

>>> sv/lms_cfg_regs.sv
// ----------------------------------------------------------------------------
// lms_cfg_regs
// Register bank; retry steps are kept as millisecond delays, converted on write.
// ----------------------------------------------------------------------------
module lms_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lms_cfg_if.sink        i_cfg,
    output lms_pkg::t_cfg  o_cfg
);

    logic [lms_pkg::CFG_DAT_W-1:0]    r_sta_budget;
    logic [lms_pkg::CFG_DAT_W-1:0]    r_quiet_guard;
    logic [3:0][lms_pkg::DELAY_W-1:0] r_retry_delay;
    logic [lms_pkg::DELAY_W-1:0]      n_delay;
    logic                             wr;

    assign i_cfg.ready = 1'b1;
    assign wr = i_cfg.valid;

    // minutes to milliseconds
    assign n_delay = lms_pkg::DELAY_W'(i_cfg.data[lms_pkg::STEP_W-1:0])
                   * lms_pkg::DELAY_W'(lms_pkg::MS_PER_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sta_budget  <= lms_pkg::RST_STA_BUDGET;
            r_quiet_guard <= lms_pkg::RST_QUIET_GUARD;
            for (int i = 0; i < 4; i++) begin
                r_retry_delay[i] <= lms_pkg::DELAY_W'(lms_pkg::RST_STEP_MIN[i])
                                  * lms_pkg::DELAY_W'(lms_pkg::MS_PER_MIN);
            end
        end else if (wr) begin
            case (i_cfg.index)
                lms_pkg::CFG_STA_BUDGET:  r_sta_budget     <= i_cfg.data;
                lms_pkg::CFG_QUIET_GUARD: r_quiet_guard    <= i_cfg.data;
                lms_pkg::CFG_RETRY_STEP0: r_retry_delay[0] <= n_delay;
                lms_pkg::CFG_RETRY_STEP1: r_retry_delay[1] <= n_delay;
                lms_pkg::CFG_RETRY_STEP2: r_retry_delay[2] <= n_delay;
                lms_pkg::CFG_RETRY_STEP3: r_retry_delay[3] <= n_delay;
                default: ;
            endcase
        end
    end

    assign o_cfg.sta_budget  = r_sta_budget;
    assign o_cfg.quiet_guard = r_quiet_guard;
    assign o_cfg.retry_delay = r_retry_delay;

endmodule

>>> sv/lms_core.sv
// ----------------------------------------------------------------------------
// lms_core
// Event register, supervisor state and the decision logic that turns one
// event into a bundle of up to three actions.
// ----------------------------------------------------------------------------
module lms_core #(
    parameter int RETRY_STEPS = 4,
    parameter int TIME_BITS   = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lms_evt_if.sink           i_evt,
    input  lms_pkg::t_cfg     i_cfg,
    output lms_pkg::t_bundle  o_bundle,
    output logic              o_load_valid,
    input  logic              i_load_ready
);

    localparam logic [1:0] LAST_STEP = 2'(RETRY_STEPS - 1);

    // event register
    logic                           r_in_valid;
    lms_pkg::t_func                 r_func;
    logic [TIME_BITS-1:0]           r_now;
    logic                           r_mode_req;
    logic                           r_force_ap;
    logic [lms_pkg::IP_W-1:0]       r_ip;
    logic [lms_pkg::CNT_W-1:0]      r_cnt;

    // supervisor state
    lms_pkg::t_link_state           r_state,    n_state;
    logic                           r_eff_mode, n_eff_mode;
    logic                           r_forced,   n_forced;
    logic [TIME_BITS-1:0]           r_deadline, n_deadline;
    logic [1:0]                     r_failed,   n_failed;
    logic [TIME_BITS-1:0]           r_next_try, n_next_try;
    logic                           r_retrying, n_retrying;
    logic [lms_pkg::CNT_W-1:0]      r_clients,  n_clients;
    logic [TIME_BITS-1:0]           r_last_act, n_last_act;
    logic                           r_pending,  n_pending;
    logic [lms_pkg::IP_W-1:0]       r_held_ip,  n_held_ip;

    logic                           load;
    logic [TIME_BITS-1:0]           d_deadline, d_retry, d_quiet;
    logic                           deadline_hit, retry_hit, quiet_ok;
    logic [1:0]                     step, failed_inc;
    logic [TIME_BITS-1:0]           sum_budget, sum_retry;
    lms_pkg::t_bundle               b;

    assign load         = r_in_valid && i_load_ready;
    assign i_evt.ready  = !r_in_valid || i_load_ready;
    assign o_load_valid = r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.valid && i_evt.ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_func     <= lms_pkg::t_func'(i_evt.func);
            r_now      <= i_evt.now_ms;
            r_mode_req <= i_evt.mode_req;
            r_force_ap <= i_evt.force_ap;
            r_ip       <= i_evt.ip_addr;
            r_cnt      <= i_evt.client_count;
        end
    end

    // modulo time arithmetic: a deadline is reached when now - deadline is
    // in the lower half of the time circle
    assign d_deadline   = r_now - r_deadline;
    assign d_retry      = r_now - r_next_try;
    assign d_quiet      = r_now - r_last_act;
    assign deadline_hit = !d_deadline[TIME_BITS-1];
    assign retry_hit    = !d_retry[TIME_BITS-1];
    assign quiet_ok     = d_quiet >= TIME_BITS'(i_cfg.quiet_guard);

    assign step       = (r_failed > LAST_STEP) ? LAST_STEP : r_failed;
    assign failed_inc = (r_failed == 2'd3) ? 2'd3 : r_failed + 2'd1;
    assign sum_budget = r_now + TIME_BITS'(i_cfg.sta_budget);
    assign sum_retry  = r_now + TIME_BITS'(i_cfg.retry_delay[step]);

    always_comb begin
        logic [1:0] k;
        k          = 2'd0;
        b.act[0]   = lms_pkg::ACT_NONE;
        b.act[1]   = lms_pkg::ACT_NONE;
        b.act[2]   = lms_pkg::ACT_NONE;
        b.ip       = '0;
        n_state    = r_state;
        n_eff_mode = r_eff_mode;
        n_forced   = r_forced;
        n_deadline = r_deadline;
        n_failed   = r_failed;
        n_next_try = r_next_try;
        n_retrying = r_retrying;
        n_clients  = r_clients;
        n_last_act = r_last_act;
        n_pending  = r_pending;
        n_held_ip  = r_held_ip;

        if (r_func == lms_pkg::FN_START) begin
            n_forced   = r_force_ap;
            n_eff_mode = r_force_ap ? lms_pkg::MODE_AP : r_mode_req;
            n_failed   = 2'd0;
            n_retrying = 1'b0;
            n_clients  = '0;
            n_last_act = r_now;
            n_pending  = 1'b0;
            if (n_eff_mode == lms_pkg::MODE_STA) begin
                n_state    = lms_pkg::ST_STA_CONNECTING;
                n_deadline = sum_budget;
                b.act[0]   = lms_pkg::ACT_STA_CONNECT;
            end else begin
                n_state  = lms_pkg::ST_AP_STARTING;
                b.act[0] = lms_pkg::ACT_START_AP;
            end
            k = 2'd1;
        end else if (r_func == lms_pkg::FN_CLIENT_COUNT) begin
            n_clients = r_cnt;
        end else if (r_func == lms_pkg::FN_ACTIVITY) begin
            n_last_act = r_now;
        end else if (r_state != lms_pkg::ST_IDLE) begin
            case (r_func)
                lms_pkg::FN_AP_STARTED: begin
                    if (r_state == lms_pkg::ST_AP_STARTING) begin
                        n_state = lms_pkg::ST_AP_UP;
                    end
                    b.act[0] = lms_pkg::ACT_EVT_AP_UP;
                    k = 2'd1;
                end
                lms_pkg::FN_STA_CONNECTED: begin
                    if (r_state == lms_pkg::ST_STA_CONNECTING) begin
                        n_state  = lms_pkg::ST_STA_UP;
                        n_failed = 2'd0;
                        b.act[0] = lms_pkg::ACT_EVT_STA_UP;
                        b.ip     = r_ip;
                        k = 2'd1;
                    end else if (r_state == lms_pkg::ST_FALLBACK_AP) begin
                        n_retrying = 1'b0;
                        n_failed   = 2'd0;
                        n_held_ip  = r_ip;
                        n_pending  = 1'b1;
                        // switch back at once when the AP side is quiet
                        if (r_clients == '0 && quiet_ok) begin
                            n_state   = lms_pkg::ST_STA_UP;
                            n_pending = 1'b0;
                            b.act[0]  = lms_pkg::ACT_STOP_AP;
                            b.act[1]  = lms_pkg::ACT_EVT_STA_UP;
                            b.ip      = r_ip;
                            k = 2'd2;
                        end
                    end
                end
                lms_pkg::FN_STA_LOST: begin
                    if (r_state == lms_pkg::ST_STA_CONNECTING) begin
                        n_state    = lms_pkg::ST_FALLBACK_AP;
                        n_retrying = 1'b0;
                        n_next_try = sum_retry;
                        n_failed   = failed_inc;
                        b.act[0]   = lms_pkg::ACT_START_AP;
                        b.act[1]   = lms_pkg::ACT_EVT_FALLBACK;
                        k = 2'd2;
                    end else if (r_state == lms_pkg::ST_STA_UP) begin
                        n_state    = lms_pkg::ST_FALLBACK_AP;
                        n_retrying = 1'b0;
                        n_next_try = sum_retry;
                        n_failed   = failed_inc;
                        b.act[0]   = lms_pkg::ACT_EVT_STA_LOST;
                        b.act[1]   = lms_pkg::ACT_START_AP;
                        b.act[2]   = lms_pkg::ACT_EVT_FALLBACK;
                        k = 2'd3;
                    end else if (r_state == lms_pkg::ST_FALLBACK_AP) begin
                        n_retrying = 1'b0;
                        n_pending  = 1'b0;
                        n_next_try = sum_retry;
                        n_failed   = failed_inc;
                    end
                end
                lms_pkg::FN_SET_MODE: begin
                    if (r_mode_req != r_eff_mode || r_forced) begin
                        n_forced   = 1'b0;
                        n_eff_mode = r_mode_req;
                        n_failed   = 2'd0;
                        n_pending  = 1'b0;
                        if (r_mode_req == lms_pkg::MODE_STA) begin
                            n_state    = lms_pkg::ST_STA_CONNECTING;
                            n_deadline = sum_budget;
                            b.act[0]   = lms_pkg::ACT_STOP_AP;
                            b.act[1]   = lms_pkg::ACT_STA_CONNECT;
                        end else begin
                            n_state  = lms_pkg::ST_AP_STARTING;
                            b.act[0] = lms_pkg::ACT_STA_DISCONNECT;
                            b.act[1] = lms_pkg::ACT_START_AP;
                        end
                        k = 2'd2;
                    end
                end
                lms_pkg::FN_TICK: begin
                    if (r_state == lms_pkg::ST_STA_CONNECTING) begin
                        if (deadline_hit) begin
                            n_state    = lms_pkg::ST_FALLBACK_AP;
                            n_retrying = 1'b0;
                            n_next_try = sum_retry;
                            n_failed   = failed_inc;
                            b.act[0]   = lms_pkg::ACT_STA_DISCONNECT;
                            b.act[1]   = lms_pkg::ACT_START_AP;
                            b.act[2]   = lms_pkg::ACT_EVT_FALLBACK;
                            k = 2'd3;
                        end
                    end else if (r_state == lms_pkg::ST_FALLBACK_AP) begin
                        if (r_pending) begin
                            if (r_clients == '0 && quiet_ok) begin
                                n_state   = lms_pkg::ST_STA_UP;
                                n_pending = 1'b0;
                                b.act[0]  = lms_pkg::ACT_STOP_AP;
                                b.act[1]  = lms_pkg::ACT_EVT_STA_UP;
                                b.ip      = r_held_ip;
                                k = 2'd2;
                            end
                        end else if (!r_retrying && retry_hit &&
                                     r_eff_mode == lms_pkg::MODE_STA) begin
                            n_retrying = 1'b1;
                            b.act[0]   = lms_pkg::ACT_STA_CONNECT;
                            k = 2'd1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // an event with no action still gives one result
        b.cnt   = (k == 2'd0) ? 2'd1 : k;
        b.state = n_state;
    end

    assign o_bundle = b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lms_pkg::ST_IDLE;
            r_eff_mode <= lms_pkg::MODE_AP;
            r_forced   <= 1'b0;
            r_deadline <= '0;
            r_failed   <= 2'd0;
            r_next_try <= '0;
            r_retrying <= 1'b0;
            r_clients  <= '0;
            r_last_act <= '0;
            r_pending  <= 1'b0;
            r_held_ip  <= '0;
        end else if (load) begin
            r_state    <= n_state;
            r_eff_mode <= n_eff_mode;
            r_forced   <= n_forced;
            r_deadline <= n_deadline;
            r_failed   <= n_failed;
            r_next_try <= n_next_try;
            r_retrying <= n_retrying;
            r_clients  <= n_clients;
            r_last_act <= n_last_act;
            r_pending  <= n_pending;
            r_held_ip  <= n_held_ip;
        end
    end

endmodule

>>> sv/lms_out_seq.sv
// ----------------------------------------------------------------------------
// lms_out_seq
// Result register: holds one bundle and hands out its actions one per
// transaction, marking the final one.
// ----------------------------------------------------------------------------
module lms_out_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lms_pkg::t_bundle  i_bundle,
    input  logic              i_load_valid,
    output logic              o_load_ready,
    lms_res_if.source         o_res
);

    logic              r_full;
    logic [1:0]        r_pos;
    lms_pkg::t_bundle  r_b;
    logic              take;
    logic              at_last;
    lms_pkg::t_action  act;

    assign take         = r_full && o_res.ready;
    assign at_last      = (r_pos + 2'd1) == r_b.cnt;
    assign o_load_ready = !r_full || (o_res.ready && at_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_pos  <= 2'd0;
        end else if (i_load_valid && o_load_ready) begin
            r_full <= 1'b1;
            r_pos  <= 2'd0;
        end else if (take && at_last) begin
            r_full <= 1'b0;
        end else if (take) begin
            r_pos <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_valid && o_load_ready) begin
            r_b <= i_bundle;
        end
    end

    assign act              = r_b.act[r_pos];
    assign o_res.valid      = r_full;
    assign o_res.action     = act;
    // the address rides only with the station up event
    assign o_res.event_ip   = (act == lms_pkg::ACT_EVT_STA_UP) ? r_b.ip : '0;
    assign o_res.link_state = r_b.state;
    assign o_res.last       = at_last;

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the link mode supervisor. Events are fed from a
// backlog by a clocked driver; a clocked monitor checks every action against
// a behavioral model of the supervisor kept in this module. Runs a directed
// walk through the fallback, retry and switch-back paths, then random
// phases at minimum, maximum and mixed register settings, one of them across
// the 48-bit time wrap.
// ----------------------------------------------------------------------------
module tb;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 64;
    localparam logic [2:0]  CFG_SPARE_A    = 3'd6;
    localparam logic [2:0]  CFG_SPARE_B    = 3'd7;
    localparam logic [47:0] HALF_RANGE     = 48'h8000_0000_0000;

    typedef struct {
        lms_pkg::t_func       func;
        logic [47:0]          now;
        logic                 mode_req;
        logic                 force_ap;
        logic [31:0]          ip;
        logic [7:0]           cnt;
    } t_link_event;

    typedef struct {
        lms_pkg::t_action     action;
        logic [31:0]          ip;
        lms_pkg::t_link_state state;
        logic                 last;
    } t_link_result;

    logic i_clk;
    logic i_rst_n;

    lms_evt_if #(.TIME_BITS(48)) evt_ch ();
    lms_res_if                   res_ch ();
    lms_cfg_if                   cfg_ch ();

    link_mode_supervisor #(
        .RETRY_STEPS (4),
        .TIME_BITS   (48)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // register copies
    logic [23:0] budget_ms;
    logic [23:0] guard_ms;
    logic [9:0]  retry_min [4];

    // supervisor state as the bench sees it
    lms_pkg::t_link_state link_st;
    logic        run_mode;
    logic        ap_forced;
    logic [47:0] sta_deadline;
    logic [1:0]  fail_count;
    logic [47:0] retry_at;
    logic        retry_active;
    logic [7:0]  ap_clients;
    logic [47:0] quiet_since;
    logic        switch_due;
    logic [31:0] held_addr;

    lms_pkg::t_action step_actions [$];
    logic [31:0]      step_ips [$];
    t_link_result     awaited_results [$];
    t_link_event      event_backlog [$];
    t_link_event      drive_item;

    logic [47:0] event_clock;
    int unsigned queued_items;
    int unsigned results_seen;
    int unsigned hold_left;
    int unsigned idle_cycles;
    int unsigned fault_count;
    logic        steady;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // behavioral model
    // ------------------------------------------------------------------------
    function automatic void note_action(lms_pkg::t_action act, logic [31:0] ip);
        if (step_actions.size() < lms_pkg::MAX_RES) begin
            step_actions.push_back(act);
            step_ips.push_back(ip);
        end
    endfunction

    // deadline counts as reached within half the time range after it
    function automatic bit deadline_passed(logic [47:0] now, logic [47:0] mark);
        logic [47:0] diff;
        diff = now - mark;
        return !diff[47];
    endfunction

    function automatic void arm_retry(logic [47:0] now);
        logic [47:0] delay;
        delay = 48'(retry_min[fail_count]) * 48'(lms_pkg::MS_PER_MIN);
        retry_at = now + delay;
        if (fail_count != 2'd3)
            fail_count++;
    endfunction

    function automatic void open_sta_attempt(logic [47:0] now);
        sta_deadline = now + 48'(budget_ms);
        note_action(lms_pkg::ACT_STA_CONNECT, '0);
    endfunction

    function automatic void fall_back(logic [47:0] now);
        link_st      = lms_pkg::ST_FALLBACK_AP;
        retry_active = 1'b0;
        arm_retry(now);
        note_action(lms_pkg::ACT_START_AP, '0);
        note_action(lms_pkg::ACT_EVT_FALLBACK, '0);
    endfunction

    function automatic void check_timers(logic [47:0] now);
        logic [47:0] quiet;
        quiet = now - quiet_since;
        if (link_st == lms_pkg::ST_STA_CONNECTING) begin
            if (deadline_passed(now, sta_deadline)) begin
                note_action(lms_pkg::ACT_STA_DISCONNECT, '0);
                fall_back(now);
            end
        end else if (link_st == lms_pkg::ST_FALLBACK_AP) begin
            if (switch_due) begin
                if (ap_clients == 8'd0 && quiet >= 48'(guard_ms)) begin
                    note_action(lms_pkg::ACT_STOP_AP, '0);
                    link_st    = lms_pkg::ST_STA_UP;
                    switch_due = 1'b0;
                    note_action(lms_pkg::ACT_EVT_STA_UP, held_addr);
                end
            end else if (!retry_active && deadline_passed(now, retry_at) &&
                         run_mode == lms_pkg::MODE_STA) begin
                retry_active = 1'b1;
                note_action(lms_pkg::ACT_STA_CONNECT, '0);
            end
        end
    endfunction

    function automatic void predict_event(t_link_event ev);
        t_link_result res;
        step_actions.delete();
        step_ips.delete();
        case (ev.func)
            lms_pkg::FN_START: begin
                ap_forced    = ev.force_ap;
                run_mode     = ev.force_ap ? lms_pkg::MODE_AP : ev.mode_req;
                fail_count   = '0;
                retry_active = 1'b0;
                ap_clients   = '0;
                quiet_since  = ev.now;
                switch_due   = 1'b0;
                if (run_mode == lms_pkg::MODE_STA) begin
                    link_st = lms_pkg::ST_STA_CONNECTING;
                    open_sta_attempt(ev.now);
                end else begin
                    link_st = lms_pkg::ST_AP_STARTING;
                    note_action(lms_pkg::ACT_START_AP, '0);
                end
            end
            lms_pkg::FN_CLIENT_COUNT: ap_clients = ev.cnt;
            lms_pkg::FN_ACTIVITY:     quiet_since = ev.now;
            default: begin
                if (link_st != lms_pkg::ST_IDLE) begin
                    case (ev.func)
                        lms_pkg::FN_AP_STARTED: begin
                            if (link_st == lms_pkg::ST_AP_STARTING)
                                link_st = lms_pkg::ST_AP_UP;
                            note_action(lms_pkg::ACT_EVT_AP_UP, '0);
                        end
                        lms_pkg::FN_STA_CONNECTED: begin
                            if (link_st == lms_pkg::ST_STA_CONNECTING) begin
                                link_st    = lms_pkg::ST_STA_UP;
                                fail_count = '0;
                                note_action(lms_pkg::ACT_EVT_STA_UP, ev.ip);
                            end else if (link_st == lms_pkg::ST_FALLBACK_AP) begin
                                retry_active = 1'b0;
                                fail_count   = '0;
                                held_addr    = ev.ip;
                                switch_due   = 1'b1;
                                check_timers(ev.now);
                            end
                        end
                        lms_pkg::FN_STA_LOST: begin
                            if (link_st == lms_pkg::ST_STA_CONNECTING) begin
                                fall_back(ev.now);
                            end else if (link_st == lms_pkg::ST_STA_UP) begin
                                note_action(lms_pkg::ACT_EVT_STA_LOST, '0);
                                fall_back(ev.now);
                            end else if (link_st == lms_pkg::ST_FALLBACK_AP) begin
                                retry_active = 1'b0;
                                switch_due   = 1'b0;
                                arm_retry(ev.now);
                            end
                        end
                        lms_pkg::FN_SET_MODE: begin
                            if (ev.mode_req != run_mode || ap_forced) begin
                                ap_forced  = 1'b0;
                                run_mode   = ev.mode_req;
                                fail_count = '0;
                                switch_due = 1'b0;
                                if (ev.mode_req == lms_pkg::MODE_STA) begin
                                    note_action(lms_pkg::ACT_STOP_AP, '0);
                                    link_st = lms_pkg::ST_STA_CONNECTING;
                                    open_sta_attempt(ev.now);
                                end else begin
                                    note_action(lms_pkg::ACT_STA_DISCONNECT, '0);
                                    link_st = lms_pkg::ST_AP_STARTING;
                                    note_action(lms_pkg::ACT_START_AP, '0);
                                end
                            end
                        end
                        default: check_timers(ev.now);
                    endcase
                end
            end
        endcase
        if (step_actions.size() == 0)
            note_action(lms_pkg::ACT_NONE, '0);
        foreach (step_actions[k]) begin
            res.action = step_actions[k];
            res.ip     = step_ips[k];
            res.state  = link_st;
            res.last   = (k == step_actions.size() - 1);
            awaited_results.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------------
    // event driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_ch.valid <= 1'b0;
        end else begin
            if (evt_ch.valid && evt_ch.ready)
                predict_event('{lms_pkg::t_func'(evt_ch.func), evt_ch.now_ms,
                                evt_ch.mode_req, evt_ch.force_ap, evt_ch.ip_addr,
                                evt_ch.client_count});
            if (!evt_ch.valid || evt_ch.ready) begin
                if (event_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 35)) begin
                    drive_item = event_backlog.pop_front();
                    evt_ch.valid        <= 1'b1;
                    evt_ch.func         <= drive_item.func;
                    evt_ch.now_ms       <= drive_item.now;
                    evt_ch.mode_req     <= drive_item.mode_req;
                    evt_ch.force_ap     <= drive_item.force_ap;
                    evt_ch.ip_addr      <= drive_item.ip;
                    evt_ch.client_count <= drive_item.cnt;
                end else begin
                    evt_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_link_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            // long hold-off now and then so the event side backs up
            if (results_seen % 250 == 100)
                hold_left = HOLD_CYCLES;
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: action %0d", res_ch.action);
                fault_count++;
            end else begin
                want = awaited_results.pop_front();
                if (res_ch.action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, res_ch.action);
                    fault_count++;
                end
                if (res_ch.event_ip !== want.ip) begin
                    $error("event_ip: expected %h, got %h", want.ip, res_ch.event_ip);
                    fault_count++;
                end
                if (res_ch.link_state !== want.state) begin
                    $error("link_state: expected %0d, got %0d", want.state, res_ch.link_state);
                    fault_count++;
                end
                if (res_ch.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, res_ch.last);
                    fault_count++;
                end
            end
        end
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= steady || $urandom_range(0, 99) >= 35;
        end
    end

    always @(posedge i_clk) begin
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic void queue_event(lms_pkg::t_func f, logic [47:0] step, logic mreq,
                                        logic fap, logic [31:0] ip, logic [7:0] cnt);
        event_clock = event_clock + step;
        event_backlog.push_back('{f, event_clock, mreq, fap, ip, cnt});
        queued_items++;
    endfunction

    // operands that the event does not use are randomized anyway
    function automatic void queue_plain(lms_pkg::t_func f, logic [47:0] step);
        queue_event(f, step, 1'($urandom), 1'($urandom), $urandom, 8'($urandom));
    endfunction

    function automatic logic [47:0] around(logic [47:0] base);
        if (base == '0)
            return 48'($urandom_range(0, 1));
        return base - 48'd1 + 48'($urandom_range(0, 2));
    endfunction

    function automatic logic [47:0] pick_time_step();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10) return '0;
        if (sel < 35) return 48'($urandom_range(0, 3000));
        if (sel < 55) return around(48'(budget_ms));
        if (sel < 70) return around(48'(guard_ms));
        if (sel < 88)
            return around(48'(retry_min[$urandom_range(0, 3)]) * 48'(lms_pkg::MS_PER_MIN));
        if (sel < 97) return 48'($urandom);
        return around(HALF_RANGE);
    endfunction

    function automatic logic [7:0] pick_clients();
        return ($urandom_range(0, 99) < 60) ? 8'd0 : 8'($urandom);
    endfunction

    // start as station, time out, retry, connect behind the AP, switch back
    function automatic void queue_link_cycle();
        queue_event(lms_pkg::FN_START, pick_time_step(), lms_pkg::MODE_STA,
                    $urandom_range(0, 9) == 0, $urandom, 8'($urandom));
        queue_plain(lms_pkg::FN_TICK, around(48'(budget_ms)));
        queue_plain(lms_pkg::FN_TICK,
                    around(48'(retry_min[$urandom_range(0, 3)]) * 48'(lms_pkg::MS_PER_MIN)));
        queue_plain(lms_pkg::FN_STA_CONNECTED, 48'($urandom_range(0, 500)));
        queue_event(lms_pkg::FN_CLIENT_COUNT, 48'($urandom_range(0, 500)), 1'($urandom),
                    1'($urandom), $urandom, pick_clients());
        queue_plain(lms_pkg::FN_TICK, around(48'(guard_ms)));
        queue_plain($urandom_range(0, 1) ? lms_pkg::FN_STA_LOST : lms_pkg::FN_SET_MODE,
                    pick_time_step());
    endfunction

    task automatic queue_random_phase(int unsigned target);
        int unsigned    first;
        int unsigned    sel;
        lms_pkg::t_func f;
        @(negedge i_clk);
        first = queued_items;
        while (queued_items - first < target) begin
            if ($urandom_range(0, 99) < 30) begin
                queue_link_cycle();
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 6)       f = lms_pkg::FN_START;
                else if (sel < 12) f = lms_pkg::FN_AP_STARTED;
                else if (sel < 25) f = lms_pkg::FN_STA_CONNECTED;
                else if (sel < 35) f = lms_pkg::FN_STA_LOST;
                else if (sel < 45) f = lms_pkg::FN_CLIENT_COUNT;
                else if (sel < 53) f = lms_pkg::FN_ACTIVITY;
                else if (sel < 60) f = lms_pkg::FN_SET_MODE;
                else               f = lms_pkg::FN_TICK;
                if (f == lms_pkg::FN_CLIENT_COUNT)
                    queue_event(f, pick_time_step(), 1'($urandom), 1'($urandom), $urandom,
                                pick_clients());
                else
                    queue_plain(f, pick_time_step());
            end
        end
    endtask

    task automatic settle();
        do
            @(negedge i_clk);
        while (event_backlog.size() != 0 || evt_ch.valid || awaited_results.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // called on a rising edge; returns on the edge that takes the write
    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        case (idx)
            lms_pkg::CFG_STA_BUDGET:  budget_ms = data;
            lms_pkg::CFG_QUIET_GUARD: guard_ms = data;
            lms_pkg::CFG_RETRY_STEP0, lms_pkg::CFG_RETRY_STEP1,
            lms_pkg::CFG_RETRY_STEP2, lms_pkg::CFG_RETRY_STEP3:
                retry_min[2'(idx - lms_pkg::CFG_RETRY_STEP0)] = data[lms_pkg::STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [23:0] budget, logic [23:0] guard,
                             logic [9:0] s0, logic [9:0] s1, logic [9:0] s2, logic [9:0] s3);
        @(posedge i_clk);
        write_reg(lms_pkg::CFG_STA_BUDGET, budget);
        write_reg(lms_pkg::CFG_QUIET_GUARD, guard);
        // upper data bits are junk on the step registers
        write_reg(lms_pkg::CFG_RETRY_STEP0, {14'($urandom), s0});
        write_reg(lms_pkg::CFG_RETRY_STEP1, {14'($urandom), s1});
        write_reg(lms_pkg::CFG_RETRY_STEP2, {14'($urandom), s2});
        write_reg(lms_pkg::CFG_RETRY_STEP3, {14'($urandom), s3});
        write_reg(CFG_SPARE_A, 24'($urandom));
        write_reg(CFG_SPARE_B, 24'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        evt_ch.valid        = 1'b0;
        evt_ch.func         = '0;
        evt_ch.now_ms       = '0;
        evt_ch.mode_req     = 1'b0;
        evt_ch.force_ap     = 1'b0;
        evt_ch.ip_addr      = '0;
        evt_ch.client_count = '0;
        res_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;

        budget_ms    = lms_pkg::RST_STA_BUDGET;
        guard_ms     = lms_pkg::RST_QUIET_GUARD;
        retry_min[0] = lms_pkg::RST_STEP_MIN[0];
        retry_min[1] = lms_pkg::RST_STEP_MIN[1];
        retry_min[2] = lms_pkg::RST_STEP_MIN[2];
        retry_min[3] = lms_pkg::RST_STEP_MIN[3];
        link_st      = lms_pkg::ST_IDLE;
        run_mode     = lms_pkg::MODE_AP;
        ap_forced    = 1'b0;
        sta_deadline = '0;
        fail_count   = '0;
        retry_at     = '0;
        retry_active = 1'b0;
        ap_clients   = '0;
        quiet_since  = '0;
        switch_due   = 1'b0;
        held_addr    = '0;
        event_clock  = '0;
        queued_items = 0;
        results_seen = 0;
        hold_left    = 0;
        idle_cycles  = 0;
        fault_count  = 0;
        steady       = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk at the reset settings
        @(negedge i_clk);
        queue_plain(lms_pkg::FN_TICK, 48'd0);                // ignored before start
        queue_plain(lms_pkg::FN_AP_STARTED, 48'd10);         // ignored before start
        queue_event(lms_pkg::FN_CLIENT_COUNT, 48'd10, lms_pkg::MODE_AP, 1'b0, '0, 8'hFF);
        // forced AP
        queue_event(lms_pkg::FN_START, 48'd10, lms_pkg::MODE_STA, 1'b1, $urandom,
                    8'($urandom));
        queue_plain(lms_pkg::FN_AP_STARTED, 48'd100);
        // clears force
        queue_event(lms_pkg::FN_SET_MODE, 48'd10, lms_pkg::MODE_AP, 1'b0, $urandom,
                    8'($urandom));
        // same mode
        queue_event(lms_pkg::FN_SET_MODE, 48'd10, lms_pkg::MODE_AP, 1'b0, $urandom,
                    8'($urandom));
        queue_plain(lms_pkg::FN_AP_STARTED, 48'd10);
        queue_plain(lms_pkg::FN_STA_CONNECTED, 48'd10);      // out of place
        queue_plain(lms_pkg::FN_STA_LOST, 48'd10);
        queue_plain(lms_pkg::FN_TICK, 48'd10);
        queue_event(lms_pkg::FN_SET_MODE, 48'd10, lms_pkg::MODE_STA, 1'b0, $urandom,
                    8'($urandom));
        queue_plain(lms_pkg::FN_TICK, 48'd29999);            // one short of the budget
        queue_plain(lms_pkg::FN_TICK, 48'd1);                // timeout, fall back
        queue_plain(lms_pkg::FN_TICK, 48'd59999);
        queue_plain(lms_pkg::FN_TICK, 48'd1);                // first retry
        queue_plain(lms_pkg::FN_STA_LOST, 48'd100);          // retry fails, next step
        queue_plain(lms_pkg::FN_TICK, 48'd120000);
        // switch at once
        queue_event(lms_pkg::FN_STA_CONNECTED, 48'd10, lms_pkg::MODE_AP, 1'b0,
                    32'hFFFF_FFFF, '0);
        queue_plain(lms_pkg::FN_STA_LOST, 48'd10);
        queue_event(lms_pkg::FN_CLIENT_COUNT, 48'd10, lms_pkg::MODE_AP, 1'b0, '0, 8'hFF);
        queue_plain(lms_pkg::FN_TICK, 48'd60000);
        // held by clients
        queue_event(lms_pkg::FN_STA_CONNECTED, 48'd10, lms_pkg::MODE_AP, 1'b0, 32'h0, '0);
        queue_event(lms_pkg::FN_CLIENT_COUNT, 48'd10, lms_pkg::MODE_AP, 1'b0, '0, 8'h00);
        queue_plain(lms_pkg::FN_ACTIVITY, 48'd10);
        queue_plain(lms_pkg::FN_TICK, 48'd59999);            // guard not yet met
        queue_plain(lms_pkg::FN_TICK, 48'd1);
        settle();

        // zero settings, no idling on either side
        configure('0, '0, '0, '0, '0, '0);
        steady = 1'b1;
        queue_random_phase(100);
        settle();
        steady = 1'b0;

        configure(24'hFF_FFFF, 24'hFF_FFFF, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        queue_random_phase(100);
        settle();

        // mixed settings with times running across the wrap
        configure(24'($urandom_range(1, 40000)), 24'($urandom_range(0, 90000)),
                  10'($urandom_range(0, 3)), 10'($urandom_range(0, 3)),
                  10'($urandom_range(0, 3)), 10'($urandom_range(0, 3)));
        event_clock = 48'hFFFF_FFFC_F2C0;
        queue_random_phase(100);
        settle();

        if (fault_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
